// File: design/assert_macros.svh
// Assertion macros shared by the RTL in this folder.
// Depends on nothing; the assertions compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLKD(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked assertion that is also checked during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLKD(lbl, clk, rst, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif
`endif

// File: design/acs_pkg.sv
// Package for the accumulator CPU step unit: transaction structs, opcodes,
// sequencer states and the flag builder. Depends on nothing.
package acs_pkg;

  localparam int MEM_WORDS_DEF = 65536;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  localparam logic [2:0] MODE_DIRECT = 3'd0;
  localparam logic [3:0] FLAGS_RESET = 4'h4;

  typedef struct packed {
    logic        kind;
    logic [15:0] load_address;
    logic [15:0] load_data;
    logic [15:0] read_word;
  } item_t;

  typedef struct packed {
    logic        halted;
    logic [15:0] pc_value;
    logic [15:0] acc_value;
    logic [3:0]  status_flags;
    logic        write_valid;
    logic [15:0] write_word;
    logic        read_used;
  } result_t;

  typedef enum logic [3:0] {
    OP_HLT, OP_LDA, OP_STA, OP_ADD, OP_TCA, OP_BRU, OP_BIP, OP_BIN,
    OP_RWD, OP_WWD, OP_SHL, OP_SHR, OP_LDX, OP_STX, OP_TIX, OP_TDX
  } opcode_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_RED_Q, ST_RED_R, ST_ACCESS, ST_DECODE, ST_INDIR, ST_EXEC
  } state_t;

  // What the pending memory access is for.
  typedef enum logic [1:0] {
    PH_LOAD, PH_FETCH, PH_POINTER, PH_DATA
  } phase_t;

  // Flags: bit 1 carry, bit 2 zero, bit 3 negative.
  function automatic logic [3:0] make_flags(logic carry, logic [15:0] acc);
    return {acc[15], (acc == 16'h0000), carry, 1'b0};
  endfunction

endpackage

// File: design/accumulator_cpu_instruction_step_unit.sv
// Top level of the accumulator CPU step unit: sequencer, register file and
// the single-port word memory. Depends on acs_pkg and assert_macros.svh.
//
//   channel   direction   handshake                payload
//   item      in          item_valid/item_stall     acs_pkg::item_t
//   result    out         result_valid/result_stall acs_pkg::result_t
//
// A load writes one word; a step fetches, then may read an indirect pointer,
// make a data access, or both. Every access uses the one memory port, and when
// MEM_WORDS is not a power of two each access first passes the reduction states
// ST_RED_Q and ST_RED_R. After reset a clearing pass writes zero to all
// MEM_WORDS words, one per cycle, while item_stall stays high. A stalled result
// holds in the output register; the next item may be taken, and its result waits.
`include "assert_macros.svh"

module accumulator_cpu_instruction_step_unit #(
  parameter int MEM_WORDS = acs_pkg::MEM_WORDS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  acs_pkg::item_t  item,
  output logic            result_valid,
  input  logic            result_stall,
  output acs_pkg::result_t result
);
  import acs_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  localparam bit POW2 = (MEM_WORDS & (MEM_WORDS - 1)) == 0;
  // Reciprocal for the address reduction: q = (a * RECIP) >> 32 is the true
  // quotient or one less, so one compare and subtract finishes the remainder.
  localparam int RECIP_W = 25;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 32) / MEM_WORDS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_WORDS - 1);
  localparam logic [16:0] MEM_WORDS_17 = 17'(MEM_WORDS);
  localparam state_t RED_FIRST = POW2 ? ST_ACCESS : ST_RED_Q;

  // Sequencer and access registers.
  state_t        state, state_next;
  phase_t        phase;
  logic [AW-1:0] clr_addr;
  logic [15:0]   maddr;
  logic          mwe;
  logic [15:0]   wdata;
  logic [7:0]    quo;
  logic [16:0]   rem;
  logic [15:0]   ir;
  logic [15:0]   ea;
  logic          is_step;
  logic [15:0]   rd_word;

  // Architectural registers.
  logic [15:0] pc, acc, index_one, index_two, index_three;
  logic [3:0]  flags;
  logic        carry;

  // Word memory, one port, read data registered.
  logic [15:0]   mem [MEM_WORDS];
  logic [15:0]   mem_rdata;
  logic          mem_en, mem_we;
  logic [AW-1:0] mem_addr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] phys_addr;
  logic [40:0]   prod;

  // Decode of the current instruction word.
  logic [15:0] cur_ir;
  opcode_t     op;
  logic        ext;
  logic [2:0]  mode;
  logic [1:0]  xsel;
  logic [7:0]  a8;
  logic [15:0] xval, base, ea_now, data_addr, data_wdata;
  logic        need_ptr, need_data, data_we, idx_live;

  // Execute results.
  logic [15:0] pc_next, acc_next, xnew;
  logic        xwr, carry_next, rebuild, halt, wv, ru;
  logic [15:0] ww;
  logic [16:0] sum17;
  logic [3:0]  flags_next;
  result_t     res_next;
  logic        out_free, exec_done;

  // The instruction word is still in the memory read register while decoding.
  assign cur_ir = (state == ST_DECODE) ? mem_rdata : ir;
  assign op     = opcode_t'(cur_ir[15:12]);
  assign ext    = cur_ir[11];
  assign mode   = cur_ir[10:8];
  assign xsel   = mode[1:0];
  assign a8     = cur_ir[7:0];

  always_comb begin
    case (xsel)
      2'd1:    xval = index_one;
      2'd2:    xval = index_two;
      2'd3:    xval = index_three;
      default: xval = 16'h0000;
    endcase
  end

  // Indexed modes add the index register; indirect modes then read a pointer.
  assign base   = {8'h00, a8} + xval;
  assign ea_now = (state == ST_INDIR) ? mem_rdata : base;

  // Index instructions only act in the plain indexed modes and use the raw
  // address field. The pointer read is skipped where no one needs the address.
  assign idx_live  = (op inside {OP_LDX, OP_STX, OP_TIX, OP_TDX}) && !mode[2] && (xsel != 2'd0);
  assign need_ptr  = !ext && mode[2] &&
                     (op inside {OP_LDA, OP_STA, OP_ADD, OP_BRU, OP_BIP, OP_BIN});
  assign need_data = !ext && ((op inside {OP_LDA, OP_STA, OP_ADD}) || idx_live);
  assign data_addr = (op inside {OP_LDA, OP_STA, OP_ADD}) ? ea_now : {8'h00, a8};
  assign data_we   = (op == OP_STA) || (op == OP_STX);
  assign data_wdata = (op == OP_STA) ? acc : xval;

  // Address reduction modulo MEM_WORDS.
  assign prod = 41'(maddr) * 41'(RECIP);
  always_comb begin
    if (POW2) begin
      phys_addr = maddr[AW-1:0];
    end else if (rem >= MEM_WORDS_17) begin
      phys_addr = AW'(rem - MEM_WORDS_17);
    end else begin
      phys_addr = AW'(rem);
    end
  end

  assign out_free  = !result_valid || !result_stall;
  assign exec_done = (state == ST_EXEC) && out_free;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_addr == LAST_ADDR) state_next = ST_IDLE;
      ST_IDLE:   if (item_valid) state_next = RED_FIRST;
      ST_RED_Q:  state_next = ST_RED_R;
      ST_RED_R:  state_next = ST_ACCESS;
      ST_ACCESS: begin
        unique case (phase) inside
          PH_FETCH:         state_next = ST_DECODE;
          PH_POINTER:       state_next = ST_INDIR;
          PH_LOAD, PH_DATA: state_next = ST_EXEC;
          default:          state_next = ST_EXEC;
        endcase
      end
      ST_DECODE: state_next = (need_ptr || need_data) ? RED_FIRST : ST_EXEC;
      ST_INDIR:  state_next = need_data ? RED_FIRST : ST_EXEC;
      ST_EXEC:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and memory port.
  always_comb begin
    item_stall = 1'b1;
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = phys_addr;
    mem_wdata  = wdata;
    unique case (state)
      ST_CLEAR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = 16'h0000;
      end
      ST_IDLE:   item_stall = 1'b0;
      ST_ACCESS: begin
        mem_en = 1'b1;
        mem_we = mwe;
      end
      default: ;
    endcase
  end

  // Instruction execution; register writes happen when the result is taken
  // into the output register.
  always_comb begin
    pc_next    = pc + 16'd1;
    acc_next   = acc;
    carry_next = carry;
    xnew       = xval;
    xwr        = 1'b0;
    halt       = 1'b0;
    wv         = 1'b0;
    ww         = 16'h0000;
    ru         = 1'b0;
    rebuild    = 1'b1;
    sum17      = {1'b0, acc} + {1'b0, mem_rdata};
    if (!is_step) begin
      pc_next = 16'h0000;
      rebuild = 1'b0;
    end else if (!ext) begin
      unique case (op) inside
        OP_HLT: halt = 1'b1;
        OP_LDA: acc_next = mem_rdata;
        OP_STA: ;
        OP_ADD: begin
          carry_next = sum17[16];
          acc_next   = sum17[15:0];
        end
        OP_TCA: acc_next = 16'h0000 - acc;
        OP_BRU: pc_next = ea;
        OP_BIP: if (flags[3:2] == 2'b00) pc_next = ea;
        OP_BIN: if (flags[3]) pc_next = ea;
        OP_RWD: begin
          acc_next = rd_word;
          ru       = 1'b1;
        end
        OP_WWD: begin
          wv = 1'b1;
          ww = acc;
        end
        OP_SHL: acc_next = {acc[14:0], 1'b0};
        OP_SHR: acc_next = {1'b0, acc[15:1]};
        OP_LDX, OP_STX: begin
          if (mode == MODE_DIRECT) begin
            halt    = 1'b1;
            rebuild = 1'b0;
          end else if (mode[2]) begin
            rebuild = 1'b0;
          end else if (op == OP_LDX) begin
            xnew = mem_rdata;
            xwr  = 1'b1;
          end
        end
        OP_TIX: begin
          if (idx_live) begin
            xnew = xval + 16'd1;
            xwr  = 1'b1;
            if (xnew == 16'h0000) pc_next = mem_rdata;
          end
        end
        OP_TDX: begin
          if (idx_live) begin
            xnew = xval - 16'd1;
            xwr  = 1'b1;
            if (xnew != 16'h0000) pc_next = mem_rdata;
          end
        end
        default: ;
      endcase
    end
    flags_next = rebuild ? make_flags(carry_next, acc_next) : flags;
    res_next = '{halted: halt, pc_value: pc_next, acc_value: acc_next,
                 status_flags: flags_next, write_valid: wv, write_word: ww,
                 read_used: ru};
  end

  // Memory array.
  always_ff @(posedge clk) begin
    if (mem_en) begin
      if (mem_we) begin
        mem[mem_addr] <= mem_wdata;
      end else begin
        mem_rdata <= mem[mem_addr];
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      pc           <= 16'h0000;
      acc          <= 16'h0000;
      index_one    <= 16'h0000;
      index_two    <= 16'h0000;
      index_three  <= 16'h0000;
      flags        <= FLAGS_RESET;
      carry        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= exec_done || (result_valid && result_stall);
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (exec_done) begin
        pc    <= pc_next;
        acc   <= acc_next;
        carry <= carry_next;
        flags <= flags_next;
        if (xwr && xsel == 2'd1) index_one   <= xnew;
        if (xwr && xsel == 2'd2) index_two   <= xnew;
        if (xwr && xsel == 2'd3) index_three <= xnew;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (exec_done) result <= res_next;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          is_step <= item.kind;
          rd_word <= item.read_word;
          if (item.kind == KIND_LOAD) begin
            maddr <= item.load_address;
            mwe   <= 1'b1;
            wdata <= item.load_data;
            phase <= PH_LOAD;
          end else begin
            maddr <= pc;
            mwe   <= 1'b0;
            phase <= PH_FETCH;
          end
        end
      end
      ST_RED_Q: quo <= prod[39:32];
      ST_RED_R: rem <= 17'(maddr) - 17'(17'(quo) * MEM_WORDS_17);
      ST_DECODE, ST_INDIR: begin
        if (state == ST_DECODE) ir <= mem_rdata;
        ea <= ea_now;
        if (state == ST_DECODE && need_ptr) begin
          maddr <= base;
          mwe   <= 1'b0;
          phase <= PH_POINTER;
        end else if (need_data) begin
          maddr <= data_addr;
          mwe   <= data_we;
          wdata <= data_wdata;
          phase <= PH_DATA;
        end
      end
      default: ;
    endcase
  end

  `ASSERT_CLKD(a_accept_leaves_idle, clk, rst, (item_valid && !item_stall) |=> (state != ST_IDLE), "accepted transaction did not start work")
  `ASSERT_CLKD(a_result_from_exec, clk, rst, $rose(result_valid) |-> ($past(state) == ST_EXEC), "result appeared outside execute")
  `ASSERT_CLKD(a_addr_in_range, clk, rst, mem_en |-> (mem_addr <= LAST_ADDR), "memory address beyond MEM_WORDS")
  `ASSERT_CLKD(a_clear_writes_zero, clk, rst, (state == ST_CLEAR) |-> (mem_we && (mem_wdata == 16'h0000)), "clearing pass wrote a nonzero word")

endmodule
